### rtl/pbbf_pkg.sv
// ----------------------------------------------------------------------------
// pbbf_pkg
// Shared constants, beat layouts and the sequencer program of the palette
// bank brightness fader.
// ----------------------------------------------------------------------------
package pbbf_pkg;

  localparam int NumBanksDef      = 32;
  localparam int ColorsPerBankDef = 16;
  localparam int RunLimit         = 16;
  localparam int ByteBias         = 32;
  localparam int ChannelMax       = 31;

  // input beat: bank, color, red, green, blue, delta, zero pad
  localparam int InTdataW   = 48;
  localparam int InBankLsb  = 0;
  localparam int InColorLsb = 5;
  localparam int InRedLsb   = 9;
  localparam int InGreenLsb = 17;
  localparam int InBlueLsb  = 25;
  localparam int InDeltaLsb = 33;

  // output beat: out_bank, out_color, packed_rgb
  localparam int OutTdataW   = 24;
  localparam int OutBankLsb  = 0;
  localparam int OutColorLsb = 5;
  localparam int OutRgbLsb   = 9;

  localparam int AccWordW = 24;

  // step addresses of the sequencer program
  typedef logic [1:0] pc_t;
  localparam pc_t PC_CLEAR = 2'd0;
  localparam pc_t PC_IDLE  = 2'd1;
  localparam pc_t PC_READ  = 2'd2;
  localparam pc_t PC_FADE  = 2'd3;

  typedef enum logic [1:0] {
    COND_CLR_LAST,
    COND_STEP_GO,
    COND_ALWAYS,
    COND_RUN_END
  } cond_e;

  typedef struct packed {
    logic  accept_en;
    logic  clear_en;
    logic  read_en;
    logic  fade_en;
    cond_e cond;
    pc_t   target;
  } ctrl_t;

  // control store: jump to target when cond holds, otherwise stay
  function automatic ctrl_t ucode(pc_t pc);
    ctrl_t w;
    w = '{accept_en: 1'b0, clear_en: 1'b0, read_en: 1'b0, fade_en: 1'b0,
          cond: COND_ALWAYS, target: PC_IDLE};
    case (pc)
      PC_CLEAR: begin
        w.clear_en = 1'b1;
        w.cond     = COND_CLR_LAST;
        w.target   = PC_IDLE;
      end
      PC_IDLE: begin
        w.accept_en = 1'b1;
        w.cond      = COND_STEP_GO;
        w.target    = PC_READ;
      end
      PC_READ: begin
        w.read_en = 1'b1;
        w.cond    = COND_ALWAYS;
        w.target  = PC_FADE;
      end
      PC_FADE: begin
        w.fade_en = 1'b1;
        w.cond    = COND_RUN_END;
        w.target  = PC_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = PC_CLEAR;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/pbbf_ram.sv
// ----------------------------------------------------------------------------
// pbbf_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds while the read enable is low.
// ----------------------------------------------------------------------------
module pbbf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/palette_bank_brightness_fader_unit.sv
// ----------------------------------------------------------------------------
// palette_bank_brightness_fader_unit
// Per-bank palette fader: accumulator bytes with a bias of 32 per channel,
// stepped by a signed delta, emitting clamped 15-bit colours.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries commands. tuser is the action: 0 loads the three
//   accumulator bytes of one colour (no output beat), 1 steps a
//   whole bank by delta. A step with zero delta, or any command naming a
//   bank (or, for a load, a colour) beyond the table, is taken and dropped.
//   m_axis returns one beat per stepped colour, from the top colour of the
//   run down to colour 0, which carries tlast.
//   A step occupies the block from its accept until its run ends: one
//   state issues the first read, then one colour per cycle, while the
//   output slot is free, goes through the read-modify-write loop over
//   the single accumulator RAM. The first output beat is registered as
//   the loop writes back the top colour. Loads and dropped commands leave it ready.
//   After reset the RAM is cleared one entry a cycle, all NUM_BANKS *
//   COLORS_PER_BANK entries (512 by default); s_axis_tready stays low then.
//   A stalled receiver holds the output beat and freezes the run; the
//   input side stays ready while a finished beat waits, between runs.
// ----------------------------------------------------------------------------
module palette_bank_brightness_fader_unit
  import pbbf_pkg::*;
#(
  parameter int NUM_BANKS       = NumBanksDef,
  parameter int COLORS_PER_BANK = ColorsPerBankDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // bank[4:0], color[8:5], red_acc[16:9], green_acc[24:17], blue_acc[32:25],
  // delta[40:33], zero[47:41]
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  // action
  input  logic                 s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // out_bank[4:0], out_color[8:5], packed_rgb[23:9]
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  output logic                 m_axis_tlast_o
);

  localparam int Depth  = NUM_BANKS * COLORS_PER_BANK;
  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int RunLen = (COLORS_PER_BANK > RunLimit) ? RunLimit : COLORS_PER_BANK;
  localparam int IdxW   = 13;

  typedef struct packed {
    logic [7:0] acc;
    logic [4:0] level;
  } fade_t;

  function automatic logic [AddrW-1:0] addr_of(logic [4:0] bank, logic [3:0] color);
    logic [IdxW-1:0] idx;
    idx = IdxW'(bank) * IdxW'(COLORS_PER_BANK) + IdxW'(color);
    return idx[AddrW-1:0];
  endfunction

  function automatic fade_t fade(logic [7:0] acc, logic [7:0] delta);
    logic signed [9:0] sum;
    logic signed [9:0] level;
    fade_t             res;
    sum   = $signed({2'b00, acc}) + $signed({{2{delta[7]}}, delta});
    level = sum - 10'(ByteBias);
    res.acc = sum[7:0];
    if (level < 0) begin
      res.level = 5'd0;
    end else if (level > 10'(ChannelMax)) begin
      res.level = 5'(ChannelMax);
    end else begin
      res.level = level[4:0];
    end
    return res;
  endfunction

  // command fields
  logic [4:0] in_bank;
  logic [3:0] in_color;
  logic [7:0] in_red, in_green, in_blue, in_delta;

  assign in_bank  = s_axis_tdata_i[InBankLsb +: 5];
  assign in_color = s_axis_tdata_i[InColorLsb +: 4];
  assign in_red   = s_axis_tdata_i[InRedLsb +: 8];
  assign in_green = s_axis_tdata_i[InGreenLsb +: 8];
  assign in_blue  = s_axis_tdata_i[InBlueLsb +: 8];
  assign in_delta = s_axis_tdata_i[InDeltaLsb +: 8];

  // sequencer
  pc_t   pc_q, pc_d;
  ctrl_t uc;
  logic  take;

  logic [AddrW-1:0] clr_q, clr_d;
  logic [4:0]       bank_q, bank_d;
  logic [3:0]       color_q, color_d;
  logic [7:0]       delta_q, delta_d;

  logic                 out_valid_q, out_valid_d;
  logic [OutTdataW-1:0] out_data_q, out_data_d;
  logic                 out_last_q, out_last_d;

  logic in_fire, bank_ok, color_ok, step_go, load_go, slot_free, fade_fire;

  logic                ram_we, ram_re;
  logic [AddrW-1:0]    ram_waddr, ram_raddr;
  logic [AccWordW-1:0] ram_wdata, ram_rdata;
  fade_t               fr, fg, fb;

  assign uc = ucode(pc_q);

  assign s_axis_tready_o = uc.accept_en;
  assign in_fire   = s_axis_tvalid_i & s_axis_tready_o;
  assign bank_ok   = {2'b00, in_bank} < 7'(NUM_BANKS);
  assign color_ok  = {3'b000, in_color} < 7'(COLORS_PER_BANK);
  assign step_go   = in_fire & s_axis_tuser_i & bank_ok & (in_delta != 8'd0);
  assign load_go   = in_fire & ~s_axis_tuser_i & bank_ok & color_ok;
  assign slot_free = ~out_valid_q | m_axis_tready_i;
  assign fade_fire = uc.fade_en & slot_free;

  always_comb begin
    case (uc.cond)
      COND_CLR_LAST: take = (clr_q == AddrW'(Depth - 1));
      COND_STEP_GO:  take = step_go;
      COND_ALWAYS:   take = 1'b1;
      COND_RUN_END:  take = fade_fire & (color_q == 4'd0);
      default:       take = 1'b0;
    endcase
    pc_d = take ? uc.target : pc_q;
  end

  // channel arithmetic on the word read for the current colour
  assign fr = fade(ram_rdata[7:0], delta_q);
  assign fg = fade(ram_rdata[15:8], delta_q);
  assign fb = fade(ram_rdata[23:16], delta_q);

  always_comb begin
    ram_we    = uc.clear_en | load_go | fade_fire;
    ram_waddr = addr_of(bank_q, color_q);
    ram_wdata = {fb.acc, fg.acc, fr.acc};
    if (uc.clear_en) begin
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (load_go) begin
      ram_waddr = addr_of(in_bank, in_color);
      ram_wdata = {in_blue, in_green, in_red};
    end
  end

  // prefetch the next colour while the current one is written back
  assign ram_re    = uc.read_en | (fade_fire & (color_q != 4'd0));
  assign ram_raddr = uc.read_en ? addr_of(bank_q, color_q)
                                : addr_of(bank_q, color_q - 4'd1);

  always_comb begin
    clr_d       = clr_q;
    bank_d      = bank_q;
    color_d     = color_q;
    delta_d     = delta_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    if (uc.clear_en) begin
      clr_d = clr_q + AddrW'(1);
    end
    if (step_go) begin
      bank_d  = in_bank;
      color_d = 4'(RunLen - 1);
      delta_d = in_delta;
    end
    if (fade_fire) begin
      if (color_q != 4'd0) begin
        color_d = color_q - 4'd1;
      end
      out_valid_d = 1'b1;
      out_data_d  = {fb.level, fg.level, fr.level, color_q, bank_q};
      out_last_d  = (color_q == 4'd0);
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bank_q     <= bank_d;
    color_q    <= color_d;
    delta_q    <= delta_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  pbbf_ram #(
    .WIDTH(AccWordW),
    .DEPTH(Depth)
  ) u_acc_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

### rtl/pbbf_checker.sv
// ----------------------------------------------------------------------------
// pbbf_checker
// Port-level checks of the palette bank brightness fader, bound to the top.
// ----------------------------------------------------------------------------
module pbbf_checker
  import pbbf_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic [InTdataW-1:0]  s_axis_tdata_i,
  input logic                 s_axis_tuser_i,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [OutTdataW-1:0] m_axis_tdata_o,
  input logic                 m_axis_tlast_o
);

  // hold a stalled output beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output beat changed");

  // the final beat of a run is colour 0
  a_last_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o[OutColorLsb +: 4] == 4'd0)
    else $error("tlast on a nonzero colour");

  // no command taken while a run is still unfinished
  a_busy_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("input ready in the middle of a run");

  // a load never starts a run
  a_load_stays_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i |=> s_axis_tready_o)
    else $error("load beat left the block busy");

  // drop a zero step and stay ready
  a_zero_step_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i &&
      s_axis_tdata_i[InDeltaLsb +: 8] == 8'd0 |=> s_axis_tready_o)
    else $error("zero step left the block busy");

endmodule

bind palette_bank_brightness_fader_unit pbbf_checker u_pbbf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tdata_i (s_axis_tdata_i),
  .s_axis_tuser_i (s_axis_tuser_i),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);

### dv/pbbf_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pbbf_tb_pkg
// Command codes shared by the fader stimulus and the fader checker.
// ----------------------------------------------------------------------------
package pbbf_tb_pkg;

  // travels on s_axis tuser
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } fade_action_e;

endpackage

### dv/palette_fade_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_fade_checker
// Watches both streams of the palette fader. It keeps its own copy of the
// accumulator table, works out the colour beats of every accepted step and
// compares each returned beat with the oldest one still owed.
// ----------------------------------------------------------------------------
module palette_fade_checker
  import pbbf_pkg::*;
  import pbbf_tb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  input  logic                 s_axis_tready_i,
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  input  logic                 s_axis_tuser_i,
  input  logic                 m_axis_tvalid_i,
  input  logic                 m_axis_tready_i,
  input  logic [OutTdataW-1:0] m_axis_tdata_i,
  input  logic                 m_axis_tlast_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam int TableDepth = NumBanksDef * ColorsPerBankDef;
  localparam int RunLen     = (ColorsPerBankDef > RunLimit) ? RunLimit : ColorsPerBankDef;

  typedef struct packed {
    logic [4:0]  bank;
    logic [3:0]  colour;
    logic [14:0] rgb;
    logic        last;
  } colour_beat_t;

  // red, green, blue bytes of every colour, bias included
  logic [2:0][7:0] acc_mem [TableDepth];
  colour_beat_t    owed_q [$];

  task automatic fade_bank(input logic [4:0] bank, input logic signed [7:0] delta);
    int           idx;
    int           sum;
    logic [4:0]   lvl [3];
    colour_beat_t beat;
    for (int c = RunLen - 1; c >= 0; c--) begin
      idx = int'(bank) * ColorsPerBankDef + c;
      for (int ch = 0; ch < 3; ch++) begin
        sum = int'(acc_mem[idx][ch]) + int'(delta);
        acc_mem[idx][ch] = sum[7:0];
        // clamp from the unwrapped sum, not the stored byte
        sum = sum - ByteBias;
        lvl[ch] = (sum < 0) ? 5'd0 : (sum > ChannelMax) ? 5'(ChannelMax) : sum[4:0];
      end
      beat.bank   = bank;
      beat.colour = c[3:0];
      beat.rgb    = {lvl[2], lvl[1], lvl[0]};
      beat.last   = (c == 0);
      owed_q.push_back(beat);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    colour_beat_t     got;
    colour_beat_t     want;
    logic [4:0]       cmd_bank;
    logic [3:0]       cmd_colour;
    logic signed [7:0] cmd_delta;
    int               idx;
    if (!rst_ni) begin
      for (int i = 0; i < TableDepth; i++) acc_mem[i] = '0;
      owed_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // check first, so a step taken on this edge cannot feed a beat on it
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.bank   = m_axis_tdata_i[OutBankLsb +: 5];
        got.colour = m_axis_tdata_i[OutColorLsb +: 4];
        got.rgb    = m_axis_tdata_i[OutRgbLsb +: 15];
        got.last   = m_axis_tlast_i;
        if (owed_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected beat bank %0d colour %0d rgb %h last %b", $time,
                   got.bank, got.colour, got.rgb, got.last);
        end else begin
          want = owed_q.pop_front();
          if (got != want) begin
            fail_count_o++;
            $display({"%0t: expected bank %0d colour %0d rgb %h last %b, ",
                      "got bank %0d colour %0d rgb %h last %b"},
                     $time, want.bank, want.colour, want.rgb, want.last,
                     got.bank, got.colour, got.rgb, got.last);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        cmd_bank   = s_axis_tdata_i[InBankLsb +: 5];
        cmd_colour = s_axis_tdata_i[InColorLsb +: 4];
        cmd_delta  = s_axis_tdata_i[InDeltaLsb +: 8];
        if (int'(cmd_bank) < NumBanksDef) begin
          if (s_axis_tuser_i == ACT_LOAD) begin
            if (int'(cmd_colour) < ColorsPerBankDef) begin
              idx = int'(cmd_bank) * ColorsPerBankDef + int'(cmd_colour);
              acc_mem[idx][0] = s_axis_tdata_i[InRedLsb +: 8];
              acc_mem[idx][1] = s_axis_tdata_i[InGreenLsb +: 8];
              acc_mem[idx][2] = s_axis_tdata_i[InBlueLsb +: 8];
            end
          end else if (cmd_delta != 0) begin
            fade_bank(cmd_bank, cmd_delta);
          end
        end
      end
      pending_o = owed_q.size();
    end
  end

endmodule

### dv/tb_palette_bank_brightness_fader_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_palette_bank_brightness_fader_unit
// Drives load and step commands into the palette fader, first a directed
// set around the byte extremes, wrap and zero step, then random traffic on
// a few busy banks, with random gaps on both streams. The checker beside
// the block predicts and compares the colour beats.
// ----------------------------------------------------------------------------
module tb_palette_bank_brightness_fader_unit;
  import pbbf_pkg::*;
  import pbbf_tb_pkg::*;

  localparam int CmdCount   = 150;
  localparam int CycleLimit = 300000;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 cmd_valid  = 1'b0;
  logic                 cmd_ready;
  logic [InTdataW-1:0]  cmd_data   = '0;
  logic                 cmd_user   = 1'b0;
  logic                 beat_valid;
  logic                 beat_ready = 1'b0;
  logic [OutTdataW-1:0] beat_data;
  logic                 beat_last;
  int                   fail_count;
  int                   pending;
  int                   cycles     = 0;
  bit                   idle_on    = 1'b1;

  palette_bank_brightness_fader_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (cmd_valid),
    .s_axis_tready_o (cmd_ready),
    .s_axis_tdata_i  (cmd_data),
    .s_axis_tuser_i  (cmd_user),
    .m_axis_tvalid_o (beat_valid),
    .m_axis_tready_i (beat_ready),
    .m_axis_tdata_o  (beat_data),
    .m_axis_tlast_o  (beat_last)
  );

  palette_fade_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (cmd_valid),
    .s_axis_tready_i (cmd_ready),
    .s_axis_tdata_i  (cmd_data),
    .s_axis_tuser_i  (cmd_user),
    .m_axis_tvalid_i (beat_valid),
    .m_axis_tready_i (beat_ready),
    .m_axis_tdata_i  (beat_data),
    .m_axis_tlast_i  (beat_last),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [InTdataW-1:0] cmd_word(input logic [4:0] bank,
                                                   input logic [3:0] colour,
                                                   input logic [7:0] red,
                                                   input logic [7:0] green,
                                                   input logic [7:0] blue,
                                                   input logic [7:0] delta);
    logic [InTdataW-1:0] w;
    w = '0;
    w[InBankLsb +: 5]  = bank;
    w[InColorLsb +: 4] = colour;
    w[InRedLsb +: 8]   = red;
    w[InGreenLsb +: 8] = green;
    w[InBlueLsb +: 8]  = blue;
    w[InDeltaLsb +: 8] = delta;
    return w;
  endfunction

  // called and returns at a falling edge; holds the beat until taken
  task automatic send_cmd(input fade_action_e act, input logic [InTdataW-1:0] data);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_user  <= act;
    cmd_data  <= data;
    do @(posedge clk); while (!cmd_ready);
    @(negedge clk);
  endtask

  // receiver stalls in bursts
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        beat_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        beat_ready <= 1'b0;
      end else begin
        beat_ready <= 1'b1;
      end
    end
  end

  initial begin
    int         hot_banks [4];
    logic [4:0] bank;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] delta;
    hot_banks = '{0, 9, 22, 31};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // untouched bank straight after the clear
    send_cmd(ACT_STEP, cmd_word(5'd3, 4'd0, 8'h00, 8'h00, 8'h00, 8'h05));
    send_cmd(ACT_LOAD, cmd_word(5'd0, 4'd15, 8'hFF, 8'h00, 8'h20, 8'h00));
    send_cmd(ACT_LOAD, cmd_word(5'd0, 4'd0, 8'h00, 8'hFF, 8'h3F, 8'hFF));
    send_cmd(ACT_LOAD, cmd_word(5'd0, 4'd7, 8'h55, 8'hAA, 8'h80, 8'h7F));
    // 0xFF + 1 wraps in the table but clamps high on the way out
    send_cmd(ACT_STEP, cmd_word(5'd0, 4'd15, 8'hFF, 8'hFF, 8'hFF, 8'h01));
    send_cmd(ACT_STEP, cmd_word(5'd0, 4'd0, 8'h00, 8'h00, 8'h00, 8'h80));
    send_cmd(ACT_STEP, cmd_word(5'd0, 4'd9, 8'h12, 8'h34, 8'h56, 8'h7F));
    send_cmd(ACT_STEP, cmd_word(5'd0, 4'd15, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    send_cmd(ACT_LOAD, cmd_word(5'd31, 4'd15, 8'h40, 8'h20, 8'h3F, 8'h80));
    send_cmd(ACT_LOAD, cmd_word(5'd31, 4'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_cmd(ACT_LOAD, cmd_word(5'd31, 4'd8, 8'h1F, 8'h21, 8'h00, 8'h01));
    send_cmd(ACT_STEP, cmd_word(5'd31, 4'd3, 8'hAA, 8'h55, 8'hF0, 8'hFF));
    send_cmd(ACT_STEP, cmd_word(5'd31, 4'd0, 8'h00, 8'h00, 8'h00, 8'h7F));
    send_cmd(ACT_STEP, cmd_word(5'd31, 4'd15, 8'h0F, 8'hF0, 8'h0F, 8'h80));
    send_cmd(ACT_STEP, cmd_word(5'd31, 4'd15, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    send_cmd(ACT_LOAD, cmd_word(5'd16, 4'd4, 8'h30, 8'h1E, 8'h3E, 8'h00));
    send_cmd(ACT_STEP, cmd_word(5'd16, 4'd0, 8'h00, 8'h00, 8'h00, 8'h40));
    send_cmd(ACT_STEP, cmd_word(5'd16, 4'd0, 8'h00, 8'h00, 8'h00, 8'hC0));

    for (int i = 0; i < CmdCount; i++) begin
      // quiet stretches now and then, none at the tail
      idle_on = (i < CmdCount - 30) && ((i / 20) % 4 != 3);
      bank = ($urandom_range(0, 9) < 7) ? 5'(hot_banks[$urandom_range(0, 3)])
                                        : 5'($urandom_range(0, 31));
      if ($urandom_range(0, 99) < 55) begin
        if ($urandom_range(0, 2) == 0) begin
          red   = 8'($urandom);
          green = 8'($urandom);
          blue  = 8'($urandom);
        end else begin
          // keep most loads near the visible band
          red   = 8'($urandom_range(16, 80));
          green = 8'($urandom_range(16, 80));
          blue  = 8'($urandom_range(16, 80));
        end
        send_cmd(ACT_LOAD, cmd_word(bank, 4'($urandom), red, green, blue, 8'($urandom)));
      end else begin
        case ($urandom_range(0, 9))
          0: delta = 8'd0;
          1, 2, 3, 4: begin
            delta = 8'($urandom_range(1, 8));
            if ($urandom_range(0, 1) == 1) delta = -delta;
          end
          default: delta = 8'($urandom);
        endcase
        send_cmd(ACT_STEP, cmd_word(bank, 4'($urandom), 8'($urandom), 8'($urandom),
                                    8'($urandom), delta));
      end
    end
    cmd_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
